### src/kvt_pkg.sv
// shared types and constants of the key value table
`timescale 1ns / 1ps

package kvt_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 7;

    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    typedef struct packed {
        logic start;
        logic step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic match;
        logic exhausted;
        logic out_free;
    } t_status;

endpackage

### src/key_value_table.sv
// key value table: bounded map with a linear search over stored keys
//
// usage: an item (op, key, value) enters on i_in_valid / o_in_ready; each item
// gives one result (read_value, hit, entry_count, dropped) on o_out_valid /
// i_out_ready. op put stores or replaces the value for the key, op get reads it
// back (0 on a miss). a put of a new key into a full table is dropped.
// timing: the scan reads one stored entry per cycle from the key and value
// memories (one read port each, registered data). a hit ends the scan when the
// registered key of the entry compares equal, a miss when the scan pointer reaches
// the entry count; the result appears in the cycle after the last scan cycle.
// one item at a time: a new item is taken only once the last search has committed.
// o_in_ready is high whenever no item is being searched, even while a result
// waits in the output register; a stalled receiver holds the finished search
// until the output register frees, and nothing is written before then.
// reset: the entry count returns to zero, which empties the table at once;
// the memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module key_value_table #(
    parameter int unsigned TABLE_ENTRIES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_op,
    input  logic signed [kvt_pkg::DATA_W-1:0]   i_key,
    input  logic signed [kvt_pkg::DATA_W-1:0]   i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [kvt_pkg::DATA_W-1:0]   o_read_value,
    output logic                                o_hit,
    output logic [kvt_pkg::COUNT_W-1:0]         o_entry_count,
    output logic                                o_dropped
);

    kvt_pkg::t_cmd    cmd;
    kvt_pkg::t_status status;

    kvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    kvt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_op          (i_op),
        .i_key         (i_key),
        .i_value       (i_value),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_read_value  (o_read_value),
        .o_hit         (o_hit),
        .o_entry_count (o_entry_count),
        .o_dropped     (o_dropped)
    );

endmodule

### src/kvt_ctrl.sv
// controller state machine of the key value table
`timescale 1ns / 1ps

module kvt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  kvt_pkg::t_status i_status,
    output kvt_pkg::t_cmd   o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.match || i_status.exhausted) begin
                    // hold the decision until the output register is free
                    if (i_status.out_free) begin
                        o_cmd.commit = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_commit_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> r_state == ST_SCAN)
        else $error("commit outside scan");

    a_commit_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_state == ST_IDLE)
        else $error("no return to idle after commit");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");
`endif

endmodule

### src/kvt_datapath.sv
// key and value memories, scan pointer, entry count and result register
`timescale 1ns / 1ps

module kvt_datapath #(
    parameter int unsigned TABLE_ENTRIES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  kvt_pkg::t_cmd                       i_cmd,
    output kvt_pkg::t_status                    o_status,
    input  logic                                i_op,
    input  logic signed [kvt_pkg::DATA_W-1:0]   i_key,
    input  logic signed [kvt_pkg::DATA_W-1:0]   i_value,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [kvt_pkg::DATA_W-1:0]   o_read_value,
    output logic                                o_hit,
    output logic [kvt_pkg::COUNT_W-1:0]         o_entry_count,
    output logic                                o_dropped
);

    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [kvt_pkg::DATA_W-1:0] key_mem [TABLE_ENTRIES];
    logic [kvt_pkg::DATA_W-1:0] val_mem [TABLE_ENTRIES];

    // latched item
    logic                              r_op;
    logic signed [kvt_pkg::DATA_W-1:0] r_key;
    logic signed [kvt_pkg::DATA_W-1:0] r_value;

    // scan pipeline
    logic [CNT_W-1:0]                  r_idx;
    logic [CNT_W-1:0]                  r_rd_pos;
    logic                              r_rd_vld;
    logic signed [kvt_pkg::DATA_W-1:0] r_rd_key;
    logic signed [kvt_pkg::DATA_W-1:0] r_rd_val;

    logic [CNT_W-1:0]                  r_count;
    logic [CNT_W-1:0]                  n_count;

    logic                              rd_en;
    logic                              full;
    logic                              put_item;
    logic                              key_we;
    logic                              val_we;
    logic [IDX_W-1:0]                  val_waddr;
    logic [CNT_W+kvt_pkg::COUNT_W-1:0] count_ext;
    logic signed [kvt_pkg::DATA_W-1:0] n_read_value;
    logic                              n_dropped;

    assign full     = (r_count == CNT_W'(TABLE_ENTRIES));
    assign put_item = (r_op == kvt_pkg::OP_PUT);
    assign rd_en    = i_cmd.step && (r_idx < r_count);

    assign o_status.match     = r_rd_vld && (r_rd_key == r_key);
    assign o_status.exhausted = (r_idx == r_count);
    assign o_status.out_free  = !o_out_valid || i_out_ready;

    assign key_we    = i_cmd.commit && put_item && !o_status.match && !full;
    assign val_we    = i_cmd.commit && put_item && (o_status.match || !full);
    assign val_waddr = o_status.match ? r_rd_pos[IDX_W-1:0] : r_count[IDX_W-1:0];

    always_comb begin
        n_count      = r_count;
        n_read_value = '0;
        n_dropped    = 1'b0;
        if (put_item) begin
            if (!o_status.match) begin
                if (full) begin
                    n_dropped = 1'b1;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
        end else if (o_status.match) begin
            n_read_value = r_rd_val;
        end
    end

    assign count_ext = {{kvt_pkg::COUNT_W{1'b0}}, n_count};

    // memories
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_key <= key_mem[r_idx[IDX_W-1:0]];
            r_rd_val <= val_mem[r_idx[IDX_W-1:0]];
        end
        if (key_we) begin
            key_mem[r_count[IDX_W-1:0]] <= r_key;
        end
        if (val_we) begin
            val_mem[val_waddr] <= r_value;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op    <= i_op;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (rd_en) begin
            r_rd_pos <= r_idx;
        end
        if (i_cmd.commit) begin
            o_read_value  <= n_read_value;
            o_hit         <= o_status.match;
            o_entry_count <= count_ext[kvt_pkg::COUNT_W-1:0];
            o_dropped     <= n_dropped;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_count     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_idx    <= '0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.step) begin
                r_rd_vld <= rd_en;
                if (rd_en) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
            end
            if (i_cmd.commit) begin
                r_count     <= n_count;
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count above table depth");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_count)
        else $error("scan pointer beyond entry count");

    a_drop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_dropped |-> !o_hit && o_read_value == '0)
        else $error("dropped item reports a hit or a value");

    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> o_out_valid)
        else $error("committed item not presented");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.commit |=> r_count == $past(r_count))
        else $error("entry count changed without commit");
`endif

endmodule

### tb/tb_key_value_table.sv
// self-checking testbench of the key value table with directed and random items
`timescale 1ns / 1ps

module tb_key_value_table;

    localparam int unsigned ENTRIES       = 64;
    localparam int unsigned IDLE_LIMIT    = 2000;
    localparam int unsigned SETTLE_CYCLES = ENTRIES + 8;

    localparam logic [kvt_pkg::DATA_W-1:0] KEY_MIN  = 32'h8000_0000;
    localparam logic [kvt_pkg::DATA_W-1:0] KEY_MAX  = 32'h7fff_ffff;
    localparam logic [kvt_pkg::DATA_W-1:0] ALL_ONES = 32'hffff_ffff;

    typedef struct packed {
        logic signed [kvt_pkg::DATA_W-1:0] read_value;
        logic                              hit;
        logic [kvt_pkg::COUNT_W-1:0]       entry_count;
        logic                              dropped;
    } t_result;

    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              i_in_valid    = 1'b0;
    logic                              o_in_ready;
    logic                              i_op          = kvt_pkg::OP_PUT;
    logic signed [kvt_pkg::DATA_W-1:0] i_key         = '0;
    logic signed [kvt_pkg::DATA_W-1:0] i_value       = '0;
    logic                              o_out_valid;
    logic                              i_out_ready   = 1'b0;
    logic signed [kvt_pkg::DATA_W-1:0] o_read_value;
    logic                              o_hit;
    logic [kvt_pkg::COUNT_W-1:0]       o_entry_count;
    logic                              o_dropped;

    logic [kvt_pkg::DATA_W-1:0] table_keys   [ENTRIES];
    logic [kvt_pkg::DATA_W-1:0] table_values [ENTRIES];
    int unsigned                table_count = 0;
    t_result                    expected_results [$];

    int unsigned n_errors    = 0;
    int unsigned n_items     = 0;
    int unsigned n_results   = 0;
    int unsigned n_hits      = 0;
    int unsigned n_drops     = 0;
    int unsigned n_misses    = 0;
    int unsigned rx_wait     = 0;
    int unsigned idle_cycles = 0;
    bit          no_idle     = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    key_value_table #(
        .TABLE_ENTRIES(ENTRIES)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_value (o_read_value),
        .o_hit        (o_hit),
        .o_entry_count(o_entry_count),
        .o_dropped    (o_dropped)
    );

    // linear search over the stored keys, then put or get
    function automatic t_result lookup_and_update(input logic op,
                                                  input logic [kvt_pkg::DATA_W-1:0] key,
                                                  input logic [kvt_pkg::DATA_W-1:0] value);
        t_result r;
        int      pos;
        int      i;
        r   = '0;
        pos = -1;
        for (i = 0; i < table_count; i++) begin
            if (pos < 0 && table_keys[i] == key) begin
                pos = i;
            end
        end
        if (op == kvt_pkg::OP_PUT) begin
            if (pos >= 0) begin
                table_values[pos] = value;
                r.hit = 1'b1;
            end else if (table_count < ENTRIES) begin
                table_keys[table_count]   = key;
                table_values[table_count] = value;
                table_count++;
            end else begin
                r.dropped = 1'b1;
            end
        end else if (pos >= 0) begin
            r.read_value = table_values[pos];
            r.hit        = 1'b1;
        end
        r.entry_count = table_count[kvt_pkg::COUNT_W-1:0];
        return r;
    endfunction

    task automatic send_item(input logic op, input logic [kvt_pkg::DATA_W-1:0] key,
                             input logic [kvt_pkg::DATA_W-1:0] value);
        int unsigned gap;
        t_result     r;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_key      <= key;
        i_value    <= value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = lookup_and_update(op, key, value);
        expected_results.push_back(r);
        n_items++;
        if (r.hit) n_hits++;
        if (r.dropped) n_drops++;
        if (op == kvt_pkg::OP_GET && !r.hit) n_misses++;
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [kvt_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2:       return '0;
            3:       return ALL_ONES;
            default: return $urandom();
        endcase
    endfunction

    // mostly stored keys, some small keys of both signs, some fully random
    task automatic send_random_item();
        logic                       op;
        logic [kvt_pkg::DATA_W-1:0] key;
        int unsigned                pick;
        op   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 9);
        if (pick < 5 && table_count != 0) begin
            key = table_keys[$urandom_range(0, table_count - 1)];
        end else if (pick < 7) begin
            key = $urandom_range(0, 15) - 8;
        end else begin
            key = $urandom();
        end
        send_item(op, key, pick_value());
    endtask

    task automatic test_empty_table();
        send_item(kvt_pkg::OP_GET, '0, $urandom());
        send_item(kvt_pkg::OP_GET, KEY_MIN, $urandom());
    endtask

    task automatic test_insert_extremes();
        send_item(kvt_pkg::OP_PUT, KEY_MIN, KEY_MAX);
        send_item(kvt_pkg::OP_PUT, KEY_MAX, KEY_MIN);
        send_item(kvt_pkg::OP_PUT, '0, '0);
        send_item(kvt_pkg::OP_PUT, ALL_ONES, ALL_ONES);
        send_item(kvt_pkg::OP_GET, KEY_MIN, ALL_ONES);
        send_item(kvt_pkg::OP_GET, KEY_MAX, '0);
        send_item(kvt_pkg::OP_GET, '0, KEY_MAX);
        send_item(kvt_pkg::OP_GET, ALL_ONES, KEY_MIN);
        send_item(kvt_pkg::OP_GET, 32'd1, '0);
    endtask

    task automatic test_replace_value();
        send_item(kvt_pkg::OP_PUT, '0, 32'h1234_5678);
        send_item(kvt_pkg::OP_GET, '0, '0);
        send_item(kvt_pkg::OP_PUT, ALL_ONES, '0);
        send_item(kvt_pkg::OP_GET, ALL_ONES, '0);
    endtask

    task automatic test_random_fill(input int unsigned count);
        repeat (count) send_random_item();
    endtask

    task automatic test_full_table();
        logic [kvt_pkg::DATA_W-1:0] new_key;
        while (table_count < ENTRIES) send_item(kvt_pkg::OP_PUT, $urandom(), $urandom());
        new_key = $urandom();
        send_item(kvt_pkg::OP_PUT, new_key, $urandom());
        send_item(kvt_pkg::OP_GET, new_key, '0);
        send_item(kvt_pkg::OP_PUT, table_keys[ENTRIES-1], KEY_MIN);
        send_item(kvt_pkg::OP_GET, table_keys[ENTRIES-1], '0);
        send_item(kvt_pkg::OP_PUT, table_keys[0], KEY_MAX);
        send_item(kvt_pkg::OP_GET, table_keys[0], '0);
    endtask

    task automatic test_back_to_back(input int unsigned count);
        no_idle = 1'b1;
        repeat (count) send_random_item();
        wait_for_results();
        no_idle = 1'b0;
    endtask

    always @(posedge i_clk) begin : result_side
        t_result     want;
        int unsigned wait_n;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            wait_n = rx_wait;
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result item: read_value %0d", o_read_value);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d", want.read_value,
                               o_read_value);
                        n_errors++;
                    end
                    if (o_hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, o_hit);
                        n_errors++;
                    end
                    if (o_entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d", want.entry_count,
                               o_entry_count);
                        n_errors++;
                    end
                    if (o_dropped !== want.dropped) begin
                        $error("dropped: expected %0d, got %0d", want.dropped, o_dropped);
                        n_errors++;
                    end
                end
                wait_n = no_idle ? 0 : $urandom_range(0, 15);
            end else if (wait_n != 0) begin
                wait_n--;
            end
            rx_wait = wait_n;
            i_out_ready <= (wait_n == 0);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("key_value_table verification failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_insert_extremes();
        test_replace_value();
        // hold off until the directed items are all back
        wait_for_results();
        test_random_fill(380);
        test_full_table();
        test_back_to_back(120);
        test_random_fill(330);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d items and %0d results: %0d hits, %0d get misses, %0d drops",
                 n_items, n_results, n_hits, n_misses, n_drops);
        $display("table grew from empty to %0d entries and was then worked at capacity",
                 table_count);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("key_value_table verification clean");
        end else begin
            $display("key_value_table verification failed");
        end
        $finish;
    end

endmodule

### files.f
src/kvt_pkg.sv
src/kvt_ctrl.sv
src/kvt_datapath.sv
src/key_value_table.sv
tb/tb_key_value_table.sv
